>>> rtl/assert_macros.svh
// Concurrent assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check on every edge outside reset.
`define RTQM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included.
`define RTQM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RTQM_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTQM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/rtqm_pkg.sv
`timescale 1ns / 1ps

package rtqm_pkg;

  localparam int SMP_W         = 16;  // reading port width
  localparam int SUM_W         = 17;  // sum of two readings
  localparam int NUM_W         = 18;  // signed sum minus offset
  localparam int DEN_W         = 16;  // scale magnitude
  localparam int PIX_W         = 10;  // pixel coordinate
  localparam int CFG_W         = 17;  // widest register
  localparam int IDX_W         = 3;
  localparam int TRY_W         = DEN_W + PIX_W;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = PIX_W / DIV_PER_STAGE;

  typedef enum logic [1:0] {
    STAT_NONE     = 2'd0,
    STAT_UNSTEADY = 2'd1,
    STAT_STEADY   = 2'd2
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_X_OFFSET  = 3'd0,
    REG_Y_OFFSET  = 3'd1,
    REG_X_SCALE   = 3'd2,
    REG_Y_SCALE   = 3'd3,
    REG_WIDTH     = 3'd4,
    REG_HEIGHT    = 3'd5,
    REG_THRESHOLD = 3'd6,
    REG_SPREAD    = 3'd7
  } cfg_idx_t;

  localparam logic [CFG_W-1:0]        RST_X_OFFSET  = 17'd110972;
  localparam logic [CFG_W-1:0]        RST_Y_OFFSET  = 17'd16867;
  localparam logic signed [DEN_W-1:0] RST_X_SCALE   = -16'sd302;
  localparam logic signed [DEN_W-1:0] RST_Y_SCALE   = 16'sd393;
  localparam logic [PIX_W-1:0]        RST_WIDTH     = 10'd240;
  localparam logic [PIX_W-1:0]        RST_HEIGHT    = 10'd320;
  localparam logic [SMP_W-1:0]        RST_THRESHOLD = 16'd8000;
  localparam logic [SMP_W-1:0]        RST_SPREAD    = 16'd100;

  // Per-axis divider state: magnitudes, partial quotient and result flags.
  typedef struct packed {
    logic             zero;  // numerator and scale differ in sign, or scale is zero
    logic             ovf;   // quotient magnitude reaches 2**PIX_W
    logic [SUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [PIX_W-1:0] quo;
  } axis_t;

  typedef struct packed {
    status_t          status;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } front_t;

  typedef struct packed {
    status_t status;
    axis_t   x;
    axis_t   y;
  } mid_t;

  function automatic axis_t axis_front(input logic [SUM_W-1:0] sum,
                                       input logic [CFG_W-1:0] offset,
                                       input logic signed [DEN_W-1:0] scale);
    logic signed [NUM_W-1:0] num;
    logic                    neg;
    logic                    dneg;
    axis_t                   a;
    num    = signed'({1'b0, sum}) - signed'({1'b0, offset});
    neg    = num[NUM_W-1];
    dneg   = scale[DEN_W-1];
    a.rem  = neg ? SUM_W'(-num) : SUM_W'(num);
    a.den  = dneg ? DEN_W'(-scale) : DEN_W'(scale);
    a.zero = (scale == '0) || (neg != dneg);
    a.ovf  = 1'b0;
    a.quo  = '0;
    return a;
  endfunction

  // Quotient is at least 2**PIX_W when rem >= den << PIX_W.
  function automatic axis_t axis_ovf(input axis_t a);
    axis_t b;
    b     = a;
    b.ovf = DEN_W'(a.rem >> PIX_W) >= a.den;
    return b;
  endfunction

  // One restoring step for quotient bit sh.
  function automatic axis_t div_step(input axis_t a, input int unsigned sh);
    logic [TRY_W-1:0] dsh;
    logic [TRY_W-1:0] rem_w;
    axis_t            b;
    b     = a;
    dsh   = TRY_W'(a.den) << sh;
    rem_w = TRY_W'(a.rem);
    if (rem_w >= dsh) begin
      b.rem = SUM_W'(rem_w - dsh);
      b.quo = a.quo | (PIX_W'(1) << sh);
    end
    return b;
  endfunction

  function automatic logic [PIX_W-1:0] pix_final(input axis_t a,
                                                  input logic [PIX_W-1:0] limit);
    logic [PIX_W-1:0] q;
    q = a.zero ? '0 : (a.ovf ? '1 : a.quo);
    return (q > limit) ? limit : q;
  endfunction

endpackage

>>> rtl/resistive_touch_qualify_and_map.sv
`timescale 1ns / 1ps
// Channel  | Ports                                          | Moves
// ---------+------------------------------------------------+--------------------------
// in       | in_valid/in_ready, in_x/y_first/second         | one beat of four readings
// out      | out_valid/out_ready, status, pressed, pixel x/y| one result beat per input
// cfg      | cfg_we, cfg_idx, cfg_data                      | register write, no wait
//
// Throughput is one beat per cycle while the output is not stalled.
// The divider is a 10-bit restoring divider, two quotient bits per stage.
// Reset (rst_n, synchronous) empties the pipeline and loads register defaults.
// A stalled output holds its beat; earlier empty stages keep filling, so input
// stays ready until every stage holds a beat.

`include "assert_macros.svh"

module resistive_touch_qualify_and_map #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rtqm_pkg::SMP_W-1:0]    in_x_first,
  input  logic [rtqm_pkg::SMP_W-1:0]    in_x_second,
  input  logic [rtqm_pkg::SMP_W-1:0]    in_y_first,
  input  logic [rtqm_pkg::SMP_W-1:0]    in_y_second,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_touch_status,
  output logic                          out_is_pressed,
  output logic [rtqm_pkg::PIX_W-1:0]    out_pixel_x,
  output logic [rtqm_pkg::PIX_W-1:0]    out_pixel_y,
  input  logic                          cfg_we,
  input  logic [rtqm_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [rtqm_pkg::CFG_W-1:0]    cfg_data
);

  localparam int MID_N  = 2 + rtqm_pkg::DIV_STAGES;  // offset, overflow, divide stages
  localparam int NUM_ST = MID_N + 2;                 // plus front and output

  // Configuration registers
  logic [rtqm_pkg::CFG_W-1:0]        x_off_r, y_off_r;
  logic signed [rtqm_pkg::DEN_W-1:0] x_scale_r, y_scale_r;
  logic [rtqm_pkg::PIX_W-1:0]        width_r, height_r;
  logic [rtqm_pkg::SMP_W-1:0]        thr_r, spread_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r   <= rtqm_pkg::RST_X_OFFSET;
      y_off_r   <= rtqm_pkg::RST_Y_OFFSET;
      x_scale_r <= rtqm_pkg::RST_X_SCALE;
      y_scale_r <= rtqm_pkg::RST_Y_SCALE;
      width_r   <= rtqm_pkg::RST_WIDTH;
      height_r  <= rtqm_pkg::RST_HEIGHT;
      thr_r     <= rtqm_pkg::RST_THRESHOLD;
      spread_r  <= rtqm_pkg::RST_SPREAD;
    end else if (cfg_we) begin
      case (rtqm_pkg::cfg_idx_t'(cfg_idx))
        rtqm_pkg::REG_X_OFFSET:  x_off_r   <= cfg_data;
        rtqm_pkg::REG_Y_OFFSET:  y_off_r   <= cfg_data;
        rtqm_pkg::REG_X_SCALE:   x_scale_r <= signed'(cfg_data[rtqm_pkg::DEN_W-1:0]);
        rtqm_pkg::REG_Y_SCALE:   y_scale_r <= signed'(cfg_data[rtqm_pkg::DEN_W-1:0]);
        rtqm_pkg::REG_WIDTH:     width_r   <= cfg_data[rtqm_pkg::PIX_W-1:0];
        rtqm_pkg::REG_HEIGHT:    height_r  <= cfg_data[rtqm_pkg::PIX_W-1:0];
        rtqm_pkg::REG_THRESHOLD: thr_r     <= cfg_data[rtqm_pkg::SMP_W-1:0];
        rtqm_pkg::REG_SPREAD:    spread_r  <= cfg_data[rtqm_pkg::SMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage advances when empty or when the next one advances.
  logic [NUM_ST-1:0] v_r, v_nxt, en;

  always_comb begin
    en[NUM_ST-1] = !v_r[NUM_ST-1] || out_ready;
    for (int i = NUM_ST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < NUM_ST; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NUM_ST-1];

  // Front stage: qualify the touch and form the raw sums.
  logic [rtqm_pkg::SMP_W-1:0] x1, x2, y1, y2, dx, dy;
  logic                       touched, steady;
  rtqm_pkg::front_t           s0_r, s0_nxt;

  always_comb begin
    x1      = rtqm_pkg::SMP_W'(in_x_first[SAMPLE_BITS-1:0]);
    x2      = rtqm_pkg::SMP_W'(in_x_second[SAMPLE_BITS-1:0]);
    y1      = rtqm_pkg::SMP_W'(in_y_first[SAMPLE_BITS-1:0]);
    y2      = rtqm_pkg::SMP_W'(in_y_second[SAMPLE_BITS-1:0]);
    touched = (x1 >= thr_r) && (x2 >= thr_r) && (y1 >= thr_r) && (y2 >= thr_r);
    dx      = (x1 > x2) ? x1 - x2 : x2 - x1;
    dy      = (y1 > y2) ? y1 - y2 : y2 - y1;
    steady  = (dx <= spread_r) && (dy <= spread_r);
    if (!touched) begin
      s0_nxt.status = rtqm_pkg::STAT_NONE;
    end else if (steady) begin
      s0_nxt.status = rtqm_pkg::STAT_STEADY;
    end else begin
      s0_nxt.status = rtqm_pkg::STAT_UNSTEADY;
    end
    // Drop the sums when not touched.
    s0_nxt.sum_x = touched ? rtqm_pkg::SUM_W'(x1) + rtqm_pkg::SUM_W'(x2) : '0;
    s0_nxt.sum_y = touched ? rtqm_pkg::SUM_W'(y1) + rtqm_pkg::SUM_W'(y2) : '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r <= s0_nxt;
    end
  end

  // Middle stages: offset and sign split, overflow check, then the divider.
  rtqm_pkg::mid_t mid_r [MID_N];
  rtqm_pkg::mid_t mid_nxt [MID_N];

  always_comb begin
    mid_nxt[0].status = s0_r.status;
    mid_nxt[0].x      = rtqm_pkg::axis_front(s0_r.sum_x, x_off_r, x_scale_r);
    mid_nxt[0].y      = rtqm_pkg::axis_front(s0_r.sum_y, y_off_r, y_scale_r);
    mid_nxt[1].status = mid_r[0].status;
    mid_nxt[1].x      = rtqm_pkg::axis_ovf(mid_r[0].x);
    mid_nxt[1].y      = rtqm_pkg::axis_ovf(mid_r[0].y);
  end

  for (genvar k = 0; k < rtqm_pkg::DIV_STAGES; k++) begin : g_div
    localparam int SH_HI = rtqm_pkg::PIX_W - 1 - rtqm_pkg::DIV_PER_STAGE * k;
    always_comb begin
      mid_nxt[k+2] = mid_r[k+1];
      for (int j = 0; j < rtqm_pkg::DIV_PER_STAGE; j++) begin
        mid_nxt[k+2].x = rtqm_pkg::div_step(mid_nxt[k+2].x, SH_HI - j);
        mid_nxt[k+2].y = rtqm_pkg::div_step(mid_nxt[k+2].y, SH_HI - j);
      end
    end
  end

  for (genvar i = 0; i < MID_N; i++) begin : g_mid
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        mid_r[i] <= mid_nxt[i];
      end
    end
  end

  // Output register: clamp and hold until taken.
  rtqm_pkg::status_t          status_r, status_nxt;
  logic [rtqm_pkg::PIX_W-1:0] pix_x_r, pix_x_nxt, pix_y_r, pix_y_nxt;

  always_comb begin
    status_nxt = mid_r[MID_N-1].status;
    pix_x_nxt  = rtqm_pkg::pix_final(mid_r[MID_N-1].x, width_r);
    pix_y_nxt  = rtqm_pkg::pix_final(mid_r[MID_N-1].y, height_r);
  end

  always_ff @(posedge clk) begin
    if (en[NUM_ST-1]) begin
      status_r <= status_nxt;
      pix_x_r  <= pix_x_nxt;
      pix_y_r  <= pix_y_nxt;
    end
  end

  assign out_touch_status = status_r;
  assign out_is_pressed   = (status_r == rtqm_pkg::STAT_STEADY);
  assign out_pixel_x      = pix_x_r;
  assign out_pixel_y      = pix_y_r;

  `RTQM_ASSERT(a_empty_out_ready, clk, rst_n, !v_r[NUM_ST-1] |-> in_ready, "input blocked with empty output stage")
  `RTQM_ASSERT(a_accept_lands, clk, rst_n, (in_valid && in_ready) |=> v_r[0], "accepted beat missing from front stage")
  `RTQM_ASSERT(a_front_hold, clk, rst_n, (v_r[0] && !en[0]) |=> (v_r[0] && $stable(s0_r)), "stalled front stage changed")
  `RTQM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

>>> verif/resistive_touch_qualify_and_map_tb.sv
`timescale 1ns / 1ps

module resistive_touch_qualify_and_map_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 120;

  typedef struct packed {
    logic [rtqm_pkg::SMP_W-1:0] xa;
    logic [rtqm_pkg::SMP_W-1:0] xb;
    logic [rtqm_pkg::SMP_W-1:0] ya;
    logic [rtqm_pkg::SMP_W-1:0] yb;
  } reading_set_t;

  typedef struct packed {
    rtqm_pkg::status_t          status;
    logic                       pressed;
    logic [rtqm_pkg::PIX_W-1:0] px;
    logic [rtqm_pkg::PIX_W-1:0] py;
  } touch_result_t;

  typedef struct {
    logic [rtqm_pkg::CFG_W-1:0]        x_off;
    logic [rtqm_pkg::CFG_W-1:0]        y_off;
    logic signed [rtqm_pkg::DEN_W-1:0] x_scl;
    logic signed [rtqm_pkg::DEN_W-1:0] y_scl;
    logic [rtqm_pkg::PIX_W-1:0]        width;
    logic [rtqm_pkg::PIX_W-1:0]        height;
    logic [rtqm_pkg::SMP_W-1:0]        thresh;
    logic [rtqm_pkg::SMP_W-1:0]        spread;
  } touch_cal_t;

  logic                       clk;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic [rtqm_pkg::SMP_W-1:0] in_x_first  = '0;
  logic [rtqm_pkg::SMP_W-1:0] in_x_second = '0;
  logic [rtqm_pkg::SMP_W-1:0] in_y_first  = '0;
  logic [rtqm_pkg::SMP_W-1:0] in_y_second = '0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic [1:0]                 out_touch_status;
  logic                       out_is_pressed;
  logic [rtqm_pkg::PIX_W-1:0] out_pixel_x;
  logic [rtqm_pkg::PIX_W-1:0] out_pixel_y;
  logic                       cfg_we      = 1'b0;
  rtqm_pkg::cfg_idx_t         cfg_idx     = rtqm_pkg::REG_X_OFFSET;
  logic [rtqm_pkg::CFG_W-1:0] cfg_data    = '0;

  touch_cal_t    cal;
  reading_set_t  pending_sets[$];
  touch_result_t expected_results[$];

  int            beats_in     = 0;
  int            results_seen = 0;
  int            mismatches   = 0;
  int            quiet_cycles = 0;
  int            gap_left     = 0;
  int            burst_left   = 0;
  int            hold_left    = 0;
  int            hold_mark    = 400;
  int            rx_mode      = 0;
  int            mode_left    = 0;
  logic          ready_now;
  reading_set_t  launch_set;
  reading_set_t  taken_set;
  touch_result_t want;

  resistive_touch_qualify_and_map i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_x_first       (in_x_first),
    .in_x_second      (in_x_second),
    .in_y_first       (in_y_first),
    .in_y_second      (in_y_second),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_touch_status (out_touch_status),
    .out_is_pressed   (out_is_pressed),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offset removal, signed divide truncating toward zero, clamp to 0..limit.
  function automatic logic [rtqm_pkg::PIX_W-1:0] map_pixel(
      input logic [rtqm_pkg::SUM_W-1:0] sum,
      input logic [rtqm_pkg::CFG_W-1:0] offset,
      input logic signed [rtqm_pkg::DEN_W-1:0] scale,
      input logic [rtqm_pkg::PIX_W-1:0] limit);
    longint num;
    longint den;
    longint q;
    num = longint'(sum) - longint'(offset);
    den = longint'(scale);
    if (den == 0) return '0;
    q = num / den;
    if (q > longint'(limit)) q = longint'(limit);
    if (q < 0) q = 0;
    return q[rtqm_pkg::PIX_W-1:0];
  endfunction

  function automatic int gap_of(input logic [rtqm_pkg::SMP_W-1:0] a,
                                input logic [rtqm_pkg::SMP_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  function automatic touch_result_t predict_touch(input reading_set_t s);
    touch_result_t              r;
    logic [rtqm_pkg::SUM_W-1:0] sx;
    logic [rtqm_pkg::SUM_W-1:0] sy;
    sx = rtqm_pkg::SUM_W'(s.xa) + rtqm_pkg::SUM_W'(s.xb);
    sy = rtqm_pkg::SUM_W'(s.ya) + rtqm_pkg::SUM_W'(s.yb);
    if (s.xa < cal.thresh || s.xb < cal.thresh || s.ya < cal.thresh || s.yb < cal.thresh) begin
      sx = '0;
      sy = '0;
      r.status = rtqm_pkg::STAT_NONE;
    end else if (gap_of(s.xa, s.xb) > int'(cal.spread) ||
                 gap_of(s.ya, s.yb) > int'(cal.spread)) begin
      r.status = rtqm_pkg::STAT_UNSTEADY;
    end else begin
      r.status = rtqm_pkg::STAT_STEADY;
    end
    r.pressed = (r.status == rtqm_pkg::STAT_STEADY);
    r.px = map_pixel(sx, cal.x_off, cal.x_scl, cal.width);
    r.py = map_pixel(sy, cal.y_off, cal.y_scl, cal.height);
    return r;
  endfunction

  function automatic logic [rtqm_pkg::SMP_W-1:0] near_reading(
      input logic [rtqm_pkg::SMP_W-1:0] base,
      input int unsigned span);
    int v;
    v = int'(base) + int'($urandom_range(2 * span, 0)) - int'(span);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[rtqm_pkg::SMP_W-1:0];
  endfunction

  // Mostly touched sets with pairs around the spread limit; some noise and near misses.
  function automatic reading_set_t random_set();
    reading_set_t s;
    int unsigned  kind;
    int unsigned  span;
    kind = $urandom_range(99, 0);
    span = int'(cal.spread) + 2;
    if (kind < 12) begin
      s = {$urandom(), $urandom()};
    end else begin
      s.xa = rtqm_pkg::SMP_W'($urandom_range(65535, cal.thresh));
      s.ya = rtqm_pkg::SMP_W'($urandom_range(65535, cal.thresh));
      s.xb = near_reading(s.xa, span);
      s.yb = near_reading(s.ya, span);
      if (kind < 24 && cal.thresh != 0) begin
        case ($urandom_range(3, 0))
          0: s.xa = rtqm_pkg::SMP_W'($urandom_range(cal.thresh - 1, 0));
          1: s.xb = rtqm_pkg::SMP_W'($urandom_range(cal.thresh - 1, 0));
          2: s.ya = rtqm_pkg::SMP_W'($urandom_range(cal.thresh - 1, 0));
          default: s.yb = rtqm_pkg::SMP_W'($urandom_range(cal.thresh - 1, 0));
        endcase
      end else if (kind < 34 && int'(cal.thresh) + int'(cal.spread) < 65535) begin
        // Sit on the threshold, pair exactly at or just past the limit.
        s.xa = cal.thresh;
        s.xb = cal.thresh + cal.spread + rtqm_pkg::SMP_W'($urandom_range(1, 0));
        s.yb = s.ya;
      end
    end
    return s;
  endfunction

  function automatic logic signed [rtqm_pkg::DEN_W-1:0] random_scale();
    int unsigned                       r;
    logic signed [rtqm_pkg::DEN_W-1:0] mag;
    r = $urandom_range(99, 0);
    if (r >= 95) return '0;
    mag = (r < 60) ? rtqm_pkg::DEN_W'($urandom_range(400, 1)) :
                     rtqm_pkg::DEN_W'($urandom_range(32767, 1));
    return $urandom_range(1, 0) ? -mag : mag;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task automatic write_reg(input rtqm_pkg::cfg_idx_t idx,
                           input logic [rtqm_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rtqm_pkg::REG_X_OFFSET:  cal.x_off  = val;
      rtqm_pkg::REG_Y_OFFSET:  cal.y_off  = val;
      rtqm_pkg::REG_X_SCALE:   cal.x_scl  = val[rtqm_pkg::DEN_W-1:0];
      rtqm_pkg::REG_Y_SCALE:   cal.y_scl  = val[rtqm_pkg::DEN_W-1:0];
      rtqm_pkg::REG_WIDTH:     cal.width  = val[rtqm_pkg::PIX_W-1:0];
      rtqm_pkg::REG_HEIGHT:    cal.height = val[rtqm_pkg::PIX_W-1:0];
      rtqm_pkg::REG_THRESHOLD: cal.thresh = val[rtqm_pkg::SMP_W-1:0];
      rtqm_pkg::REG_SPREAD:    cal.spread = val[rtqm_pkg::SMP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [rtqm_pkg::CFG_W-1:0] xo,
                           input logic [rtqm_pkg::CFG_W-1:0] yo,
                           input logic signed [rtqm_pkg::DEN_W-1:0] xs,
                           input logic signed [rtqm_pkg::DEN_W-1:0] ys,
                           input logic [rtqm_pkg::PIX_W-1:0] w,
                           input logic [rtqm_pkg::PIX_W-1:0] h,
                           input logic [rtqm_pkg::SMP_W-1:0] th,
                           input logic [rtqm_pkg::SMP_W-1:0] sp);
    write_reg(rtqm_pkg::REG_X_OFFSET, xo);
    write_reg(rtqm_pkg::REG_Y_OFFSET, yo);
    write_reg(rtqm_pkg::REG_X_SCALE, rtqm_pkg::CFG_W'(xs));
    write_reg(rtqm_pkg::REG_Y_SCALE, rtqm_pkg::CFG_W'(ys));
    write_reg(rtqm_pkg::REG_WIDTH, rtqm_pkg::CFG_W'(w));
    write_reg(rtqm_pkg::REG_HEIGHT, rtqm_pkg::CFG_W'(h));
    write_reg(rtqm_pkg::REG_THRESHOLD, rtqm_pkg::CFG_W'(th));
    write_reg(rtqm_pkg::REG_SPREAD, rtqm_pkg::CFG_W'(sp));
  endtask

  task automatic randomize_calibration();
    logic [rtqm_pkg::PIX_W-1:0] w;
    logic [rtqm_pkg::PIX_W-1:0] h;
    logic [rtqm_pkg::SMP_W-1:0] th;
    logic [rtqm_pkg::SMP_W-1:0] sp;
    int unsigned                r;
    r  = $urandom_range(99, 0);
    w  = (r < 10) ? 10'd1023 : (r < 20) ? 10'd1 :
         rtqm_pkg::PIX_W'($urandom_range(1023, 1));
    h  = (r >= 90) ? 10'd1023 : (r >= 80) ? 10'd1 :
         rtqm_pkg::PIX_W'($urandom_range(1023, 1));
    r  = $urandom_range(99, 0);
    th = (r < 10) ? 16'd0 : (r < 14) ? 16'hFFFF :
         rtqm_pkg::SMP_W'($urandom_range(40000, 0));
    r  = $urandom_range(99, 0);
    sp = (r < 15) ? 16'd0 : (r < 20) ? 16'hFFFF :
         rtqm_pkg::SMP_W'($urandom_range(3000, 0));
    write_all(rtqm_pkg::CFG_W'($urandom_range(131070, 0)),
              rtqm_pkg::CFG_W'($urandom_range(131070, 0)),
              random_scale(), random_scale(), w, h, th, sp);
  endtask

  task automatic add_set(input logic [rtqm_pkg::SMP_W-1:0] xa,
                         input logic [rtqm_pkg::SMP_W-1:0] xb,
                         input logic [rtqm_pkg::SMP_W-1:0] ya,
                         input logic [rtqm_pkg::SMP_W-1:0] yb);
    pending_sets.push_back({xa, xb, ya, yb});
  endtask

  // Hold the sender back until every beat is in and every result is out.
  task automatic drain();
    @(negedge clk);
    while (pending_sets.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Input driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      taken_set = {in_x_first, in_x_second, in_y_first, in_y_second};
      expected_results.push_back(predict_touch(taken_set));
      beats_in <= beats_in + 1;
    end
    if (rst_n && (!in_valid || in_ready)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_sets.size() != 0) begin
        launch_set = pending_sets.pop_front();
        in_x_first  <= launch_set.xa;
        in_x_second <= launch_set.xb;
        in_y_first  <= launch_set.ya;
        in_y_second <= launch_set.yb;
        in_valid    <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left   <= ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(12, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, armed by the number of input beats taken.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (beats_in >= hold_mark) begin
      hold_left <= HOLD_CYCLES;
      hold_mark <= hold_mark + 700;
    end
  end

  // Result monitor and receiver stall pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_results.pop_front();
        if (out_touch_status !== want.status)
          report_mismatch($sformatf("result %0d touch_status %0d, want %0d",
                                    results_seen, out_touch_status, want.status));
        if (out_is_pressed !== want.pressed)
          report_mismatch($sformatf("result %0d is_pressed %0d, want %0d",
                                    results_seen, out_is_pressed, want.pressed));
        if (out_pixel_x !== want.px)
          report_mismatch($sformatf("result %0d pixel_x %0d, want %0d",
                                    results_seen, out_pixel_x, want.px));
        if (out_pixel_y !== want.py)
          report_mismatch($sformatf("result %0d pixel_y %0d, want %0d",
                                    results_seen, out_pixel_y, want.py));
      end
    end
    if (mode_left == 0) begin
      rx_mode   <= $urandom_range(3, 0);
      mode_left <= $urandom_range(300, 30);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      0: ready_now = 1'b1;
      1: ready_now = ($urandom_range(9, 0) < 7);
      2: ready_now = ($urandom_range(3, 0) == 0);
      default: ready_now = (mode_left % 3 == 0);
    endcase
    out_ready <= ready_now && (hold_left == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cal.x_off  = rtqm_pkg::RST_X_OFFSET;
    cal.y_off  = rtqm_pkg::RST_Y_OFFSET;
    cal.x_scl  = rtqm_pkg::RST_X_SCALE;
    cal.y_scl  = rtqm_pkg::RST_Y_SCALE;
    cal.width  = rtqm_pkg::RST_WIDTH;
    cal.height = rtqm_pkg::RST_HEIGHT;
    cal.thresh = rtqm_pkg::RST_THRESHOLD;
    cal.spread = rtqm_pkg::RST_SPREAD;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults after reset: threshold and spread edges, bit patterns.
    @(negedge clk);
    add_set(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_set(16'd8000, 16'd8000, 16'd8000, 16'd8000);
    add_set(16'd7999, 16'd9000, 16'd9000, 16'd9000);
    add_set(16'd9000, 16'd9100, 16'd20000, 16'd20100);
    add_set(16'd9000, 16'd9101, 16'd20000, 16'd20000);
    add_set(16'd30000, 16'd30000, 16'd20000, 16'd20101);
    add_set(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
    add_set(16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA);
    add_set(16'd50000, 16'd50050, 16'd40000, 16'd39950);
    drain();

    // Zero threshold and spread, unit scales, widest screen.
    write_all('0, '0, 16'sd1, -16'sd1, 10'd1023, 10'd1023, 16'd0, 16'd0);
    @(negedge clk);
    add_set(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_set(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001);
    add_set(16'h0001, 16'h0000, 16'h0000, 16'h0000);
    add_set(16'h0200, 16'h0200, 16'h0000, 16'h0000);
    add_set(16'h01FF, 16'h01FF, 16'h0100, 16'h0100);
    drain();

    // Offsets of 131070, most negative and most positive scale, top threshold.
    write_all(17'd131070, 17'd131070, -16'sd32768, 16'sd32767, 10'd1023, 10'd1023,
              16'hFFFF, 16'hFFFF);
    @(negedge clk);
    add_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_set(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_set(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // Zero scale on X, then zero screen size on both axes.
    write_all('0, '0, 16'sd0, 16'sd5, 10'd0, 10'd1023, 16'd0, 16'hFFFF);
    @(negedge clk);
    add_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_set(16'h0000, 16'hFFFF, 16'h1234, 16'h0000);
    drain();
    write_reg(rtqm_pkg::REG_X_SCALE, rtqm_pkg::CFG_W'(16'sd1));
    write_reg(rtqm_pkg::REG_HEIGHT, rtqm_pkg::CFG_W'(10'd0));
    @(negedge clk);
    add_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_set(16'h4000, 16'h8000, 16'h0010, 16'h0020);
    drain();

    // Random calibrations, each followed by a full drain.
    repeat (8) begin
      randomize_calibration();
      @(negedge clk);
      repeat (240) pending_sets.push_back(random_set());
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
